### src/distance_vector_table_update_top_macros.svh
// Assertion macros shared by the checker of the routing table block.
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_TOP_MACROS_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVTU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DVTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/dvtu_pkg.sv
// Package with constants and types shared by the routing table modules.
package dvtu_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NODE_W      = 8;
    localparam int COST_W      = 14;
    localparam int STATUS_W    = 2;

    localparam logic [COST_W-1:0]   COST_INF    = 14'd9999;
    localparam logic [NODE_W-1:0]   OWN_NODE_RST = 8'd1;

    localparam logic [STATUS_W-1:0] ST_IMPROVED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic load;
        logic search_step;
        logic list_push;
    } dvtu_cmd_t;

    typedef struct packed {
        logic match;
        logic at_end;
        logic out_free;
    } dvtu_sts_t;

endpackage

### src/distance_vector_table_update_top.sv
// An advertisement is accepted while idle, then the valid entries are searched in order until
// the destination matches or the last entry is reached, then every valid entry is listed;
// a listing step waits while the output register holds a result that is not yet taken.
// A new advertisement is taken only after the listing of the last one is done, as the
// single table read port is shared by the search and the listing.
// Reset (aresetn low, synchronous): own node 1, one valid entry (own node at cost 0),
// no result pending.
module distance_vector_table_update_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // dest_node[7:0], link_cost[21:8], zero fill[23:22]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // entry_node[7:0], entry_cost[21:8], update_status[23:22]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    dvtu_pkg::dvtu_cmd_t           cmd;
    dvtu_pkg::dvtu_sts_t           sts;
    logic [dvtu_pkg::NODE_W-1:0]   out_node;
    logic [dvtu_pkg::COST_W-1:0]   out_cost;
    logic [dvtu_pkg::STATUS_W-1:0] out_status;

    assign cfg_ready = 1'b1;

    dvtu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dvtu_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_dest    (s_tdata[7:0]),
        .in_link    (s_tdata[21:8]),
        .cfg_we     (cfg_valid),
        .cfg_node   (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_node   (out_node),
        .out_cost   (out_cost),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {out_status, out_cost, out_node};

endmodule

### src/dvtu_ctrl.sv
// Controller state machine that sequences accept, search and listing.
module dvtu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  dvtu_pkg::dvtu_sts_t sts,
    output dvtu_pkg::dvtu_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_LIST   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next      = state_reg;
        cmd.load        = 1'b0;
        cmd.search_step = 1'b0;
        cmd.list_push   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.search_step = 1'b1;
                if (sts.match || sts.at_end) begin
                    state_next = S_LIST;
                end
            end
            S_LIST: begin
                if (sts.out_free) begin
                    cmd.list_push = 1'b1;
                    if (sts.at_end) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

### src/dvtu_datapath.sv
// Datapath holding the routing table, the entry counter and the output register.
module dvtu_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dvtu_pkg::dvtu_cmd_t                 cmd,
    output dvtu_pkg::dvtu_sts_t                 sts,
    input  logic [dvtu_pkg::NODE_W-1:0]         in_dest,
    input  logic [dvtu_pkg::COST_W-1:0]         in_link,
    input  logic                                cfg_we,
    input  logic [dvtu_pkg::NODE_W-1:0]         cfg_node,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [dvtu_pkg::NODE_W-1:0]         out_node,
    output logic [dvtu_pkg::COST_W-1:0]         out_cost,
    output logic [dvtu_pkg::STATUS_W-1:0]       out_status,
    output logic                                out_last
);

    logic [dvtu_pkg::NODE_W-1:0]   node_reg [dvtu_pkg::TABLE_DEPTH];
    logic [dvtu_pkg::COST_W-1:0]   cost_reg [dvtu_pkg::TABLE_DEPTH];
    logic [dvtu_pkg::NODE_W-1:0]   own_reg;
    logic [dvtu_pkg::CNT_W-1:0]    count_reg;
    logic [dvtu_pkg::IDX_W-1:0]    idx_reg;
    logic [dvtu_pkg::NODE_W-1:0]   dest_reg;
    logic [dvtu_pkg::COST_W-1:0]   offered_reg;
    logic [dvtu_pkg::STATUS_W-1:0] status_reg;
    logic                          out_valid_reg;
    logic [dvtu_pkg::NODE_W-1:0]   out_node_reg;
    logic [dvtu_pkg::COST_W-1:0]   out_cost_reg;
    logic [dvtu_pkg::STATUS_W-1:0] out_status_reg;
    logic                          out_last_reg;

    logic [dvtu_pkg::NODE_W-1:0]   node_rd;
    logic [dvtu_pkg::COST_W-1:0]   cost_rd;
    logic [dvtu_pkg::COST_W-1:0]   offered_in;
    logic                          improve;
    logic                          has_room;

    // Entry zero is this node itself and its cost is always zero.
    always_comb begin
        if (idx_reg == '0) begin
            node_rd = own_reg;
            cost_rd = '0;
        end else begin
            node_rd = node_reg[idx_reg];
            cost_rd = cost_reg[idx_reg];
        end
        offered_in   = (in_link > dvtu_pkg::COST_INF) ? dvtu_pkg::COST_INF : in_link;
        improve      = (offered_reg < cost_rd);
        has_room     = (count_reg < dvtu_pkg::CNT_W'(dvtu_pkg::TABLE_DEPTH));
        sts.match    = (node_rd == dest_reg);
        sts.at_end   = ({1'b0, idx_reg} == (count_reg - dvtu_pkg::CNT_W'(1)));
        sts.out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg       <= dvtu_pkg::OWN_NODE_RST;
            count_reg     <= dvtu_pkg::CNT_W'(1);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                own_reg <= cfg_node;
            end
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.search_step) begin
                if (sts.match || sts.at_end) begin
                    idx_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + dvtu_pkg::IDX_W'(1);
                end
                if (!sts.match && sts.at_end && has_room) begin
                    count_reg <= count_reg + dvtu_pkg::CNT_W'(1);
                end
            end else if (cmd.list_push) begin
                idx_reg <= idx_reg + dvtu_pkg::IDX_W'(1);
            end
            if (cmd.list_push) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dest_reg    <= in_dest;
            offered_reg <= offered_in;
        end
        if (cmd.search_step) begin
            if (sts.match) begin
                if (improve) begin
                    cost_reg[idx_reg] <= offered_reg;
                    status_reg        <= dvtu_pkg::ST_IMPROVED;
                end else begin
                    status_reg <= dvtu_pkg::ST_UNCHANGED;
                end
            end else if (sts.at_end) begin
                if (has_room) begin
                    node_reg[count_reg[dvtu_pkg::IDX_W-1:0]] <= dest_reg;
                    cost_reg[count_reg[dvtu_pkg::IDX_W-1:0]] <= offered_reg;
                    status_reg                               <= dvtu_pkg::ST_INSERTED;
                end else begin
                    status_reg <= dvtu_pkg::ST_FULL;
                end
            end
        end
        if (cmd.list_push) begin
            out_node_reg   <= node_rd;
            out_cost_reg   <= cost_rd;
            out_status_reg <= status_reg;
            out_last_reg   <= sts.at_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_node   = out_node_reg;
    assign out_cost   = out_cost_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

### src/dvtu_checker.sv
// Port-level assertion checker for the routing table block, bound to the top level.
`include "distance_vector_table_update_top_macros.svh"

module dvtu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result holds its contents.
    `DVTU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // An accepted advertisement blocks the input until its listing is done.
    `DVTU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // No new advertisement is taken while a listing is still in progress.
    `DVTU_ASSERT_NOW(a_no_accept_mid_list, m_tvalid && !m_tlast, !s_tready)

    // Within one listing the next entry follows at once with the same status.
    `DVTU_ASSERT_NEXT(a_status_steady, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[23:22] == $past(m_tdata[23:22])))

endmodule

bind distance_vector_table_update_top dvtu_checker u_dvtu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### bench/tb_top.sv
// Self-checking testbench that streams route advertisements and checks every listed table entry.
`timescale 1ns / 100ps

module tb_top;

    localparam int DATA_W        = 24;
    localparam int LINK_MAX      = (1 << dvtu_pkg::COST_W) - 1;
    localparam int SETTLE_CYCLES = 2 * dvtu_pkg::TABLE_DEPTH + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 90;

    typedef struct {
        logic [dvtu_pkg::NODE_W-1:0]   node;
        logic [dvtu_pkg::COST_W-1:0]   cost;
        logic [dvtu_pkg::STATUS_W-1:0] status;
        logic                          last;
    } listed_entry_t;

    // Tracks the routing table and the entries that the block is expected to list.
    class route_table_board;
        logic [dvtu_pkg::NODE_W-1:0] own_node;
        logic [dvtu_pkg::NODE_W-1:0] node_ids [dvtu_pkg::TABLE_DEPTH];
        logic [dvtu_pkg::COST_W-1:0] route_costs [dvtu_pkg::TABLE_DEPTH];
        int unsigned                 valid_count;
        listed_entry_t               pending_listing [$];
        int unsigned                 errors;
        int unsigned                 adverts;
        int unsigned                 listed;
        int unsigned                 outcome_seen [4];

        function new();
            own_node = dvtu_pkg::OWN_NODE_RST;
            foreach (node_ids[i]) begin
                node_ids[i]    = '0;
                route_costs[i] = dvtu_pkg::COST_INF;
            end
            node_ids[0]    = own_node;
            route_costs[0] = '0;
            valid_count    = 1;
        endfunction

        function void set_own_node(logic [dvtu_pkg::NODE_W-1:0] value);
            own_node    = value;
            node_ids[0] = value;
        endfunction

        function void apply_advert(logic [dvtu_pkg::NODE_W-1:0] dest,
                                   logic [dvtu_pkg::COST_W-1:0] link);
            int                            offered;
            int                            hit;
            logic [dvtu_pkg::STATUS_W-1:0] outcome;
            listed_entry_t                 row;
            offered = int'(link) + int'(route_costs[0]);
            if (offered > int'(dvtu_pkg::COST_INF)) begin
                offered = int'(dvtu_pkg::COST_INF);
            end
            hit = -1;
            for (int i = 0; i < valid_count; i++) begin
                if (hit < 0 && node_ids[i] == dest) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                if (offered < int'(route_costs[hit])) begin
                    route_costs[hit] = dvtu_pkg::COST_W'(offered);
                    outcome = dvtu_pkg::ST_IMPROVED;
                end else begin
                    outcome = dvtu_pkg::ST_UNCHANGED;
                end
            end else if (valid_count < dvtu_pkg::TABLE_DEPTH) begin
                node_ids[valid_count]    = dest;
                route_costs[valid_count] = dvtu_pkg::COST_W'(offered);
                valid_count++;
                outcome = dvtu_pkg::ST_INSERTED;
            end else begin
                outcome = dvtu_pkg::ST_FULL;
            end
            adverts++;
            outcome_seen[outcome]++;
            for (int i = 0; i < valid_count; i++) begin
                row.node   = node_ids[i];
                row.cost   = route_costs[i];
                row.status = outcome;
                row.last   = (i == valid_count - 1);
                pending_listing.push_back(row);
            end
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("%0t ns: mismatch: %s", $time, what);
        endtask

        task check_result(input logic [DATA_W-1:0] data, input logic last);
            listed_entry_t want;
            listed++;
            if (pending_listing.size() == 0) begin
                report_mismatch($sformatf("entry %h last %b arrived with nothing expected",
                                          data, last));
                return;
            end
            want = pending_listing.pop_front();
            if (data[dvtu_pkg::NODE_W-1:0] !== want.node) begin
                report_mismatch($sformatf("entry_node %0d, expected %0d",
                                          data[dvtu_pkg::NODE_W-1:0], want.node));
            end
            if (data[dvtu_pkg::NODE_W+dvtu_pkg::COST_W-1:dvtu_pkg::NODE_W] !== want.cost) begin
                report_mismatch($sformatf("entry_cost %0d, expected %0d",
                    data[dvtu_pkg::NODE_W+dvtu_pkg::COST_W-1:dvtu_pkg::NODE_W], want.cost));
            end
            if (data[DATA_W-1:dvtu_pkg::NODE_W+dvtu_pkg::COST_W] !== want.status) begin
                report_mismatch($sformatf("update_status %0d, expected %0d",
                                          data[DATA_W-1:dvtu_pkg::NODE_W+dvtu_pkg::COST_W],
                                          want.status));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("last_entry %b, expected %b", last, want.last));
            end
        endtask
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_data  = '0;

    route_table_board            board;
    int                          src_run_free = 0;
    int                          snk_run_free = 0;
    int                          sink_hold_cycles = 0;
    logic [dvtu_pkg::NODE_W-1:0] mid_own_node;

    distance_vector_table_update_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Mostly short gaps, a few long ones, and now and then a run without any gap.
    function automatic int idle_gap(ref int run_free);
        int r;
        if (run_free > 0) begin
            run_free--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            run_free = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_advert(input logic [dvtu_pkg::NODE_W-1:0] dest,
                               input logic [dvtu_pkg::COST_W-1:0] link);
        int gap;
        gap = idle_gap(src_run_free);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W - dvtu_pkg::NODE_W - dvtu_pkg::COST_W){1'b0}}, link, dest};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.apply_advert(dest, link);
    endtask

    task automatic random_advert();
        int                          pick;
        int                          idx;
        logic [dvtu_pkg::NODE_W-1:0] dest;
        logic [dvtu_pkg::COST_W-1:0] link;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            idx  = $urandom_range(0, board.valid_count - 1);
            dest = board.node_ids[idx];
            case ($urandom_range(0, 2))
                0: begin
                    link = dvtu_pkg::COST_W'($urandom_range(0, board.route_costs[idx]));
                end
                1: begin
                    link = dvtu_pkg::COST_W'($urandom_range(0, dvtu_pkg::COST_INF));
                end
                default: begin
                    link = dvtu_pkg::COST_W'($urandom_range(0, LINK_MAX));
                end
            endcase
        end else begin
            dest = dvtu_pkg::NODE_W'($urandom_range(0, (1 << dvtu_pkg::NODE_W) - 1));
            link = dvtu_pkg::COST_W'($urandom_range(0,
                       (pick < 85) ? int'(dvtu_pkg::COST_INF) : LINK_MAX));
        end
        send_advert(dest, link);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_listing.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_own_node(input logic [dvtu_pkg::NODE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        board.set_own_node(value);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata, m_tlast);
        end
    end

    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge aclk);
                sink_hold_cycles = 0;
            end
            gap = idle_gap(snk_run_free);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        #6_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [dvtu_pkg::NODE_W-1:0] own_values [4];
        board        = new();
        mid_own_node = dvtu_pkg::NODE_W'($urandom_range(2, 254));
        own_values   = '{8'd0, 8'd255, mid_own_node, dvtu_pkg::OWN_NODE_RST};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset own node: own match, extremes, saturation,
        // equal and lower costs, filling the table, then a drop on the full table.
        send_advert(8'd1, 14'd5);
        send_advert(8'd0, 14'd0);
        send_advert(8'd255, 14'd16383);
        send_advert(8'd255, 14'd9999);
        send_advert(8'd255, 14'd9998);
        send_advert(8'd0, 14'd0);
        send_advert(8'd170, 14'd10000);
        send_advert(8'd170, 14'd9999);
        send_advert(8'd85, 14'd5461);
        for (int k = 0; k < dvtu_pkg::TABLE_DEPTH - 5; k++) begin
            send_advert(dvtu_pkg::NODE_W'(20 + k), dvtu_pkg::COST_W'(k * 900));
        end
        send_advert(8'd200, 14'd100);
        send_advert(8'd85, 14'd3);
        send_advert(8'd1, 14'd0);

        foreach (own_values[p]) begin
            wait_drained();
            write_own_node(own_values[p]);
            if (p == 0) begin
                sink_hold_cycles = HOLD_CYCLES;
            end
            repeat (RANDOM_ITEMS) random_advert();
        end
        wait_drained();

        $display("Sent %0d advertisements under own node ids 1, 0, 255, %0d and 1 again.",
                 board.adverts, mid_own_node);
        $display("Checked %0d listed entries; %0d improved, %0d unchanged, %0d inserted, %0d dropped.",
                 board.listed,
                 board.outcome_seen[dvtu_pkg::ST_IMPROVED],
                 board.outcome_seen[dvtu_pkg::ST_UNCHANGED],
                 board.outcome_seen[dvtu_pkg::ST_INSERTED],
                 board.outcome_seen[dvtu_pkg::ST_FULL]);
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/dvtu_pkg.sv
src/dvtu_ctrl.sv
src/dvtu_datapath.sv
src/distance_vector_table_update_top.sv
src/dvtu_checker.sv
bench/tb_top.sv
